[sv/fpp_pkg.sv]
// Shared types, widths, register indexes and arithmetic helpers for the fisheye projection core.
// Used by fpp_mul, fpp_div and fisheye_point_projection_core. Depends on nothing else.
package fpp_pkg;

	// Operand widths of the pipelined multiplier fpp_mul.
	localparam int MUL_A_W  = 40;
	localparam int MUL_B_W  = 33;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int MUL_LO_W = 20;

	// Quotient, divisor and remainder widths of the direction divider.
	localparam int DIV_Q_W = 31;
	localparam int DIV_N_W = 32;
	localparam int DIV_R_W = DIV_N_W + DIV_Q_W - 1;

	// Width of the pixel sum ahead of saturation.
	localparam int SUM_W = 46;

	localparam int CFG_IDX_W = 4;

	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic signed [MUL_B_W-1:0] mul_b_t;
	typedef logic signed [MUL_P_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X  = 4'd0,
		REG_FOCAL_Y  = 4'd1,
		REG_CENTER_X = 4'd2,
		REG_CENTER_Y = 4'd3,
		REG_COEF_K1  = 4'd4,
		REG_COEF_K2  = 4'd5,
		REG_COEF_K3  = 4'd6,
		REG_COEF_K4  = 4'd7
	} cfg_reg_t;

	// One in Q.28.
	localparam prod_t ONE_Q28 = prod_t'(1) <<< 28;

	// Arctangent of 2^-i in Q2.30, rounded to nearest; from i = 10 on it is 2^(30-i).
	function automatic logic signed [32:0] fpp_atan(input int i);
		logic signed [32:0] t;
		case (i)
			0:       t = 33'sd843314857;
			1:       t = 33'sd497837829;
			2:       t = 33'sd263043837;
			3:       t = 33'sd133525159;
			4:       t = 33'sd67021687;
			5:       t = 33'sd33543516;
			6:       t = 33'sd16775851;
			7:       t = 33'sd8388437;
			8:       t = 33'sd4194283;
			9:       t = 33'sd2097149;
			default: t = 33'sd1 <<< (30 - i);
		endcase
		return t;
	endfunction

	// Product scaled down by 2^sh, rounded toward zero.
	function automatic prod_t fpp_trunc(input prod_t p, input int sh);
		prod_t bias;
		bias = p[MUL_P_W-1] ? ((prod_t'(1) <<< sh) - prod_t'(1)) : prod_t'(0);
		return (p + bias) >>> sh;
	endfunction

	// Clamp to the signed 32 bit range.
	function automatic logic signed [31:0] fpp_sat32(input sum_t v);
		logic signed [31:0] r;
		if (v > sum_t'(32'sh7fffffff)) begin
			r = 32'sh7fffffff;
		end else if (v < sum_t'(-33'sh080000000)) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[sv/fpp_mul.sv]
// Two-stage signed multiplier built from two partial products of at most 21 by 33 bits.
// Depends on fpp_pkg for operand and product types.
module fpp_mul (
	input  logic            clk,
	input  logic            en,
	input  fpp_pkg::mul_a_t a,
	input  fpp_pkg::mul_b_t b,
	output fpp_pkg::prod_t  p
);

	logic signed [fpp_pkg::MUL_LO_W+fpp_pkg::MUL_B_W:0]   lo_s1;
	logic signed [fpp_pkg::MUL_P_W-fpp_pkg::MUL_LO_W-1:0] hi_s1;
	fpp_pkg::prod_t                                         p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= $signed({1'b0, a[fpp_pkg::MUL_LO_W-1:0]}) * b;
			hi_s1 <= $signed(a[fpp_pkg::MUL_A_W-1:fpp_pkg::MUL_LO_W]) * b;
			p_s2  <= (fpp_pkg::prod_t'(hi_s1) <<< fpp_pkg::MUL_LO_W) + fpp_pkg::prod_t'(lo_s1);
		end
	end

	assign p = p_s2;

endmodule

[sv/fpp_div.sv]
// Pipelined restoring divider: q = floor(num * 2^30 / den), one quotient bit per stage.
// Depends on fpp_pkg for its widths; the quotient must fit in DIV_Q_W bits.
module fpp_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [fpp_pkg::DIV_N_W-1:0]  num,
	input  logic [fpp_pkg::DIV_N_W-1:0]  den,
	output logic [fpp_pkg::DIV_Q_W-1:0]  q
);

	logic [fpp_pkg::DIV_R_W-1:0] rem_s [0:fpp_pkg::DIV_Q_W-1];
	logic [fpp_pkg::DIV_N_W-1:0] den_s [0:fpp_pkg::DIV_Q_W-1];
	logic [fpp_pkg::DIV_Q_W-1:0] quo_s [0:fpp_pkg::DIV_Q_W-1];

	for (genvar k = 0; k < fpp_pkg::DIV_Q_W; k++) begin : g_step
		localparam int BIT = fpp_pkg::DIV_Q_W - 1 - k;
		logic [fpp_pkg::DIV_R_W-1:0] r_in;
		logic [fpp_pkg::DIV_N_W-1:0] d_in;
		logic [fpp_pkg::DIV_Q_W-1:0] q_in;
		logic [fpp_pkg::DIV_R_W-1:0] d_sh;

		if (k == 0) begin : g_first
			assign r_in = fpp_pkg::DIV_R_W'(num) << (fpp_pkg::DIV_Q_W - 1);
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign d_in = den_s[k-1];
			assign q_in = quo_s[k-1];
		end

		assign d_sh = fpp_pkg::DIV_R_W'(d_in) << BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= d_in;
				if (r_in >= d_sh) begin
					rem_s[k] <= r_in - d_sh;
					quo_s[k] <= q_in | (fpp_pkg::DIV_Q_W'(1) << BIT);
				end else begin
					rem_s[k] <= r_in;
					quo_s[k] <= q_in;
				end
			end
		end
	end

	assign q = quo_s[fpp_pkg::DIV_Q_W-1];

endmodule

[sv/fisheye_point_projection_core.sv]
// Top level of the fisheye (equidistant polynomial) point projection core.
// Depends on fpp_pkg, fpp_mul and fpp_div.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    point_x, point_y, point_z
//   out      out_valid / out_ready  pixel_u, pixel_v, valid_res
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One point is taken every cycle while the skid buffer is empty. The pipeline length is
// set by the square root (32 stages), the angle rotation (30 stages) and the polynomial
// and scaling multiplies (2 stages each). All pipeline stages move together; a one-entry
// skid buffer behind the output stage catches a beat the sink refuses, and in_ready is
// simply "skid buffer empty". Reset clears the stage valid bits, the skid buffer and the
// configuration registers. cfg_ready is always high; the user must write configuration
// only while the core is empty, and the core itself does not enforce it.
module fisheye_point_projection_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             point_x,
	input  logic signed [31:0]             point_y,
	input  logic signed [31:0]             point_z,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             pixel_u,
	output logic signed [31:0]             pixel_v,
	output logic                           valid_res,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fpp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);

	localparam int LAT       = 90;
	localparam int ISQ_STEPS = 32;
	localparam int COR_STEPS = 30;

	// Per-point flags that ride along with the data through every stage.
	typedef struct packed {
		logic vld;
		logic zpos;
		logic onaxis;
		logic xneg;
		logic yneg;
	} side_t;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] z;
	} pt_t;

	// Configuration registers.
	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [31:0] coef_k1_q, coef_k2_q, coef_k3_q, coef_k4_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= '0;
			focal_y_q  <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			coef_k1_q  <= '0;
			coef_k2_q  <= '0;
			coef_k3_q  <= '0;
			coef_k4_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fpp_pkg::REG_FOCAL_X:  focal_x_q  <= cfg_data;
				fpp_pkg::REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				fpp_pkg::REG_CENTER_X: center_x_q <= cfg_data;
				fpp_pkg::REG_CENTER_Y: center_y_q <= cfg_data;
				fpp_pkg::REG_COEF_K1:  coef_k1_q  <= cfg_data;
				fpp_pkg::REG_COEF_K2:  coef_k2_q  <= cfg_data;
				fpp_pkg::REG_COEF_K3:  coef_k3_q  <= cfg_data;
				fpp_pkg::REG_COEF_K4:  coef_k4_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances whenever the skid buffer is free.
	logic adv;
	logic skid_vld_q;

	assign adv      = !skid_vld_q;
	assign in_ready = adv;

	// Flags are known at the input: an on-axis point has X = Y = 0.
	side_t side_in;
	side_t side_s [1:LAT];

	assign side_in.vld    = in_valid;
	assign side_in.zpos   = !point_z[31] && (point_z != '0);
	assign side_in.onaxis = (point_x == '0) && (point_y == '0);
	assign side_in.xneg   = point_x[31];
	assign side_in.yneg   = point_y[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= LAT; j++) begin
				side_s[j] <= '0;
			end
		end else if (adv) begin
			side_s[1] <= side_in;
			for (int j = 2; j <= LAT; j++) begin
				side_s[j] <= side_s[j-1];
			end
		end
	end

	// Magnitudes and depth travel to the angle and direction stages.
	pt_t         pt_in;
	pt_t         pt_s [1:35];
	logic [63:0] sq_x_s2, sq_y_s2;
	logic [63:0] n_s3;

	assign pt_in.ax = point_x[31] ? 32'(-point_x) : point_x;
	assign pt_in.ay = point_y[31] ? 32'(-point_y) : point_y;
	assign pt_in.z  = point_z;

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s[1] <= pt_in;
			for (int j = 2; j <= 35; j++) begin
				pt_s[j] <= pt_s[j-1];
			end
			sq_x_s2 <= pt_s[1].ax * pt_s[1].ax;
			sq_y_s2 <= pt_s[1].ay * pt_s[1].ay;
			n_s3    <= sq_x_s2 + sq_y_s2;
		end
	end

	// Integer square root, one result bit per stage: rho = floor(sqrt(X^2 + Y^2)).
	logic [63:0] isq_rem_s  [0:ISQ_STEPS-1];
	logic [63:0] isq_root_s [0:ISQ_STEPS-1];
	logic [31:0] rho_s35;

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
		localparam logic [64:0] BIT = 65'd1 << (62 - 2 * k);
		logic [63:0] rem_in;
		logic [63:0] root_in;
		logic [64:0] trial;

		if (k == 0) begin : g_first
			assign rem_in  = n_s3;
			assign root_in = '0;
		end else begin : g_next
			assign rem_in  = isq_rem_s[k-1];
			assign root_in = isq_root_s[k-1];
		end

		assign trial = {1'b0, root_in} + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				if ({1'b0, rem_in} >= trial) begin
					isq_rem_s[k]  <= rem_in - trial[63:0];
					isq_root_s[k] <= (root_in >> 1) + BIT[63:0];
				end else begin
					isq_rem_s[k]  <= rem_in;
					isq_root_s[k] <= root_in >> 1;
				end
			end
		end
	end

	assign rho_s35 = isq_root_s[ISQ_STEPS-1][31:0];

	// Vectoring rotation: theta = atan2(rho, Z) in Q2.30, one iteration per stage.
	logic signed [35:0] cor_x_s [0:COR_STEPS-1];
	logic signed [35:0] cor_y_s [0:COR_STEPS-1];
	logic signed [32:0] cor_z_s [0:COR_STEPS-1];

	for (genvar k = 0; k < COR_STEPS; k++) begin : g_cor
		localparam logic signed [32:0] ANG = fpp_pkg::fpp_atan(k);
		logic signed [35:0] x_in, y_in, xs, ys;
		logic signed [32:0] z_in;

		if (k == 0) begin : g_first
			assign x_in = $signed({4'b0000, pt_s[35].z});
			assign y_in = $signed({4'b0000, rho_s35});
			assign z_in = '0;
		end else begin : g_next
			assign x_in = cor_x_s[k-1];
			assign y_in = cor_y_s[k-1];
			assign z_in = cor_z_s[k-1];
		end

		assign xs = x_in >>> k;
		assign ys = y_in >>> k;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!y_in[35]) begin
					cor_x_s[k] <= x_in + ys;
					cor_y_s[k] <= y_in - xs;
					cor_z_s[k] <= z_in + ANG;
				end else begin
					cor_x_s[k] <= x_in - ys;
					cor_y_s[k] <= y_in + xs;
					cor_z_s[k] <= z_in - ANG;
				end
			end
		end
	end

	// Direction cosines |X|*2^30/rho and |Y|*2^30/rho, ready at stage 66.
	logic [fpp_pkg::DIV_Q_W-1:0] qx_s66, qy_s66;

	fpp_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (pt_s[35].ax),
		.den (rho_s35),
		.q   (qx_s66)
	);

	fpp_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (pt_s[35].ay),
		.den (rho_s35),
		.q   (qy_s66)
	);

	// Angle in Q.28 (negative angles clamp to zero) and its square.
	logic [28:0]        th_s    [66:80];
	logic [29:0]        t2_s    [69:77];
	logic signed [31:0] dir_x_s [67:83];
	logic signed [31:0] dir_y_s [67:83];
	logic [29:0]        t2_w;
	fpp_pkg::prod_t     m_t2_p;

	always_ff @(posedge clk) begin
		if (adv) begin
			th_s[66] <= cor_z_s[COR_STEPS-1][32] ? '0 : cor_z_s[COR_STEPS-1][30:2];
			for (int j = 67; j <= 80; j++) begin
				th_s[j] <= th_s[j-1];
			end
			t2_s[69] <= t2_w;
			for (int j = 70; j <= 77; j++) begin
				t2_s[j] <= t2_s[j-1];
			end
			dir_x_s[67] <= side_s[66].xneg ? -$signed({1'b0, qx_s66}) : $signed({1'b0, qx_s66});
			dir_y_s[67] <= side_s[66].yneg ? -$signed({1'b0, qy_s66}) : $signed({1'b0, qy_s66});
			for (int j = 68; j <= 83; j++) begin
				dir_x_s[j] <= dir_x_s[j-1];
				dir_y_s[j] <= dir_y_s[j-1];
			end
		end
	end

	fpp_mul u_mul_t2 (
		.clk (clk),
		.en  (adv),
		.a   (fpp_pkg::mul_a_t'({1'b0, th_s[66]})),
		.b   (fpp_pkg::mul_b_t'({1'b0, th_s[66]})),
		.p   (m_t2_p)
	);

	assign t2_w = m_t2_p[57:28];

	// Horner evaluation of the distortion polynomial, three stages per step.
	fpp_pkg::mul_a_t h1_s71, h2_s74, h3_s77, h4_s80;
	fpp_pkg::prod_t  m_h1_p, m_h2_p, m_h3_p, m_h4_p;

	fpp_mul u_mul_h1 (
		.clk (clk),
		.en  (adv),
		.a   (fpp_pkg::mul_a_t'($signed(coef_k4_q))),
		.b   (fpp_pkg::mul_b_t'({1'b0, t2_w})),
		.p   (m_h1_p)
	);

	fpp_mul u_mul_h2 (
		.clk (clk),
		.en  (adv),
		.a   (h1_s71),
		.b   (fpp_pkg::mul_b_t'({1'b0, t2_s[71]})),
		.p   (m_h2_p)
	);

	fpp_mul u_mul_h3 (
		.clk (clk),
		.en  (adv),
		.a   (h2_s74),
		.b   (fpp_pkg::mul_b_t'({1'b0, t2_s[74]})),
		.p   (m_h3_p)
	);

	fpp_mul u_mul_h4 (
		.clk (clk),
		.en  (adv),
		.a   (h3_s77),
		.b   (fpp_pkg::mul_b_t'({1'b0, t2_s[77]})),
		.p   (m_h4_p)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			h1_s71 <= fpp_pkg::mul_a_t'(fpp_pkg::prod_t'($signed(coef_k3_q))
				+ fpp_pkg::fpp_trunc(m_h1_p, 28));
			h2_s74 <= fpp_pkg::mul_a_t'(fpp_pkg::prod_t'($signed(coef_k2_q))
				+ fpp_pkg::fpp_trunc(m_h2_p, 28));
			h3_s77 <= fpp_pkg::mul_a_t'(fpp_pkg::prod_t'($signed(coef_k1_q))
				+ fpp_pkg::fpp_trunc(m_h3_p, 28));
			h4_s80 <= fpp_pkg::mul_a_t'(fpp_pkg::ONE_Q28 + fpp_pkg::fpp_trunc(m_h4_p, 28));
		end
	end

	// Distorted angle, then per axis: w = theta_d * dir, p = w * focal.
	fpp_pkg::mul_a_t td_s83, w_x_s86, w_y_s86;
	fpp_pkg::prod_t  m_td_p, m_wx_p, m_wy_p, m_px_p, m_py_p;
	fpp_pkg::sum_t   p_x_s89, p_y_s89;

	fpp_mul u_mul_td (
		.clk (clk),
		.en  (adv),
		.a   (h4_s80),
		.b   (fpp_pkg::mul_b_t'({1'b0, th_s[80]})),
		.p   (m_td_p)
	);

	fpp_mul u_mul_wx (
		.clk (clk),
		.en  (adv),
		.a   (td_s83),
		.b   (fpp_pkg::mul_b_t'(dir_x_s[83])),
		.p   (m_wx_p)
	);

	fpp_mul u_mul_wy (
		.clk (clk),
		.en  (adv),
		.a   (td_s83),
		.b   (fpp_pkg::mul_b_t'(dir_y_s[83])),
		.p   (m_wy_p)
	);

	fpp_mul u_mul_px (
		.clk (clk),
		.en  (adv),
		.a   (w_x_s86),
		.b   (fpp_pkg::mul_b_t'({1'b0, focal_x_q})),
		.p   (m_px_p)
	);

	fpp_mul u_mul_py (
		.clk (clk),
		.en  (adv),
		.a   (w_y_s86),
		.b   (fpp_pkg::mul_b_t'({1'b0, focal_y_q})),
		.p   (m_py_p)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			td_s83  <= fpp_pkg::mul_a_t'(fpp_pkg::fpp_trunc(m_td_p, 28));
			w_x_s86 <= fpp_pkg::mul_a_t'(fpp_pkg::fpp_trunc(m_wx_p, 30));
			w_y_s86 <= fpp_pkg::mul_a_t'(fpp_pkg::fpp_trunc(m_wy_p, 30));
			p_x_s89 <= fpp_pkg::sum_t'(fpp_pkg::fpp_trunc(m_px_p, 28));
			p_y_s89 <= fpp_pkg::sum_t'(fpp_pkg::fpp_trunc(m_py_p, 28));
		end
	end

	// Output stage: add the principal point and saturate. An on-axis point lands on
	// the principal point, and a point at or behind the camera reports zeros.
	fpp_pkg::sum_t      sum_u, sum_v;
	logic signed [31:0] pix_u_s90, pix_v_s90;

	assign sum_u = (side_s[89].onaxis ? fpp_pkg::sum_t'(0) : p_x_s89)
		+ fpp_pkg::sum_t'({1'b0, center_x_q});
	assign sum_v = (side_s[89].onaxis ? fpp_pkg::sum_t'(0) : p_y_s89)
		+ fpp_pkg::sum_t'({1'b0, center_y_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_u_s90 <= side_s[89].zpos ? fpp_pkg::fpp_sat32(sum_u) : '0;
			pix_v_s90 <= side_s[89].zpos ? fpp_pkg::fpp_sat32(sum_v) : '0;
		end
	end

	// Skid buffer: holds the output beat that the sink refused while the pipeline moved.
	logic signed [31:0] skid_u_q, skid_v_q;
	logic               skid_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (side_s[LAT].vld && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_u_q  <= pix_u_s90;
			skid_v_q  <= pix_v_s90;
			skid_ok_q <= side_s[LAT].zpos;
		end
	end

	assign out_valid = skid_vld_q || side_s[LAT].vld;
	assign pixel_u   = skid_vld_q ? skid_u_q  : pix_u_s90;
	assign pixel_v   = skid_vld_q ? skid_v_q  : pix_v_s90;
	assign valid_res = skid_vld_q ? skid_ok_q : side_s[LAT].zpos;

`ifndef ASSERT_OFF
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> pixel_u == '0 && pixel_v == '0)
		else $error("point behind the camera produced a nonzero pixel");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(side_s[LAT].vld && !out_ready))
		else $error("skid buffer filled without a refused output beat");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && out_ready |=> !skid_vld_q)
		else $error("skid buffer kept a beat that the sink accepted");
`endif

endmodule
